@@ rtl/fpga_passive_serial_configurator_defines.svh @@
// Assertion macros used by the checker file of the configurator.
`ifndef FPGA_PASSIVE_SERIAL_CONFIGURATOR_DEFINES_SVH
`define FPGA_PASSIVE_SERIAL_CONFIGURATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fpsc_pkg.sv @@
// Types and constants of the passive serial configurator.
package fpsc_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PULSE    = 3'd1;
  localparam logic [2:0] PH_STATUS   = 3'd2;
  localparam logic [2:0] PH_LOAD     = 3'd3;
  localparam logic [2:0] PH_DONEWAIT = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;
  localparam logic [2:0] PH_ERROR    = 3'd6;

  localparam logic [1:0] REG_BITSTREAM_BYTES = 2'd0;
  localparam logic [1:0] REG_NCONFIG_LOW     = 2'd1;
  localparam logic [1:0] REG_STATUS_WAIT     = 2'd2;
  localparam logic [1:0] REG_DONE_TIMEOUT    = 2'd3;

  localparam logic [31:0] RST_BITSTREAM_BYTES = 32'd1;
  localparam logic [15:0] RST_NCONFIG_LOW     = 16'd50;
  localparam logic [15:0] RST_STATUS_WAIT     = 16'd300;
  localparam logic [15:0] RST_DONE_TIMEOUT    = 16'd200;

  // One result record: a single beat, or a byte that is shifted out as eight beats.
  typedef struct packed {
    logic [7:0] data;
    logic       multi;
    logic       idle_high;
    logic       nconfig;
    logic [2:0] phase;
  } fpsc_rec_t;

endpackage

@@ rtl/fpsc_core.sv @@
// Input register, configuration registers and the sequencing state update.
module fpsc_core
  import fpsc_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [31:0]      in_declared_size,
  input  logic [7:0]       in_data_byte,
  input  logic             in_nstatus_level,
  input  logic             in_cdone_level,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  logic             rec_ready,
  output logic             rec_valid,
  output fpsc_rec_t        rec
);

  localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = {TICK_COUNT_BITS{1'b1}};

  logic        ir_valid_r;
  logic [1:0]  ir_op_r;
  logic [31:0] ir_size_r;
  logic [7:0]  ir_byte_r;
  logic        ir_nstat_r;
  logic        ir_cdone_r;

  logic [31:0] bb_r;
  logic [15:0] nlow_r, swait_r, dto_r;

  logic [2:0]                 phase_r, phase_nxt;
  logic [TICK_COUNT_BITS-1:0] tick_r, tick_nxt, tick_inc;
  logic [31:0]                bytes_r, bytes_nxt, bytes_inc;
  logic                       ncfg_r, ncfg_nxt;
  logic                       d0_r, d0_nxt;
  logic                       multi;
  logic [15:0]                thr;
  logic                       hit;
  logic                       accept, advance;

  assign advance  = ir_valid_r && rec_ready;
  assign in_stall = ir_valid_r && !rec_ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (accept) begin
      ir_valid_r <= 1'b1;
    end else if (advance) begin
      ir_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_op_r    <= in_opcode;
      ir_size_r  <= in_declared_size;
      ir_byte_r  <= in_data_byte;
      ir_nstat_r <= in_nstatus_level;
      ir_cdone_r <= in_cdone_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r    <= RST_BITSTREAM_BYTES;
      nlow_r  <= RST_NCONFIG_LOW;
      swait_r <= RST_STATUS_WAIT;
      dto_r   <= RST_DONE_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BITSTREAM_BYTES: bb_r    <= cfg_wdata;
        REG_NCONFIG_LOW:     nlow_r  <= cfg_wdata[15:0];
        REG_STATUS_WAIT:     swait_r <= cfg_wdata[15:0];
        REG_DONE_TIMEOUT:    dto_r   <= cfg_wdata[15:0];
        default:             bb_r    <= bb_r;
      endcase
    end
  end

  // The tick counter saturates; a saturated count meets any threshold.
  assign tick_inc  = (tick_r != TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign bytes_inc = bytes_r + 32'd1;

  always_comb begin
    case (phase_r)
      PH_PULSE:  thr = nlow_r;
      PH_STATUS: thr = swait_r;
      default:   thr = dto_r;
    endcase
  end

  assign hit = (CW'(tick_inc) >= CW'(thr)) || (tick_inc == TICK_MAX);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bytes_nxt = bytes_r;
    ncfg_nxt  = ncfg_r;
    d0_nxt    = d0_r;
    multi     = 1'b0;
    case (ir_op_r)
      OP_START: begin
        if (phase_r == PH_IDLE || phase_r == PH_DONE || phase_r == PH_ERROR) begin
          d0_nxt    = 1'b0;
          bytes_nxt = '0;
          tick_nxt  = '0;
          if (ir_size_r != bb_r) begin
            ncfg_nxt  = 1'b1;
            phase_nxt = PH_ERROR;
          end else begin
            ncfg_nxt  = 1'b0;
            phase_nxt = PH_PULSE;
          end
        end
      end
      OP_TICK: begin
        case (phase_r)
          PH_PULSE: begin
            tick_nxt = tick_inc;
            if (hit) begin
              ncfg_nxt  = 1'b1;
              tick_nxt  = '0;
              phase_nxt = (swait_r == 16'd0) ? PH_LOAD : PH_STATUS;
            end
          end
          PH_STATUS: begin
            tick_nxt = tick_inc;
            if (hit) begin
              tick_nxt  = '0;
              phase_nxt = PH_LOAD;
            end
          end
          PH_LOAD: begin
            if (!ir_nstat_r) begin
              phase_nxt = PH_ERROR;
            end
          end
          PH_DONEWAIT: begin
            if (ir_cdone_r) begin
              d0_nxt    = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              tick_nxt = tick_inc;
              if (hit) begin
                phase_nxt = PH_ERROR;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      OP_DATA: begin
        if (phase_r == PH_LOAD) begin
          if (!ir_nstat_r) begin
            phase_nxt = PH_ERROR;
          end else begin
            multi     = 1'b1;
            d0_nxt    = ir_byte_r[7];
            bytes_nxt = bytes_inc;
            if (bytes_inc == bb_r) begin
              tick_nxt  = '0;
              phase_nxt = PH_DONEWAIT;
            end
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bytes_r <= '0;
      ncfg_r  <= 1'b1;
      d0_r    <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bytes_r <= bytes_nxt;
      ncfg_r  <= ncfg_nxt;
      d0_r    <= d0_nxt;
    end
  end

  assign rec_valid     = advance;
  assign rec.data      = multi ? ir_byte_r : {7'd0, d0_nxt};
  assign rec.multi     = multi;
  assign rec.idle_high = (phase_nxt == PH_DONE);
  assign rec.nconfig   = ncfg_nxt;
  assign rec.phase     = phase_nxt;

endmodule

@@ rtl/fpsc_ser.sv @@
// Two-entry result queue that expands byte records into eight serial beats.
module fpsc_ser
  import fpsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rec_valid,
  input  fpsc_rec_t rec,
  output logic      rec_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_data0_level,
  output logic      out_dclk_pulse,
  output logic      out_dclk_idle_high,
  output logic      out_nconfig_level,
  output logic [2:0] out_phase,
  output logic      out_last
);

  fpsc_rec_t  q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic [2:0] bit_r;
  fpsc_rec_t  head;
  logic       beat, pop, push;

  assign head      = q_r[rd_ptr_r];
  assign rec_ready = (count_r != 2'd2);
  assign push      = rec_valid;
  assign out_valid = (count_r != 2'd0);
  assign beat      = out_valid && !out_stall;
  assign pop       = beat && out_last;

  assign out_data0_level    = head.multi ? head.data[bit_r] : head.data[0];
  assign out_dclk_pulse     = head.multi;
  assign out_dclk_idle_high = head.idle_high;
  assign out_nconfig_level  = head.nconfig;
  assign out_phase          = head.phase;
  assign out_last           = !head.multi || (bit_r == 3'd7);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      bit_r    <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        bit_r    <= 3'd0;
      end else if (beat) begin
        bit_r <= bit_r + 3'd1;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/fpga_passive_serial_configurator.sv @@
// Top level of the passive serial FPGA configurator.
//
//   Channel  Direction  Handshake           Beat contents
//   in_      input      in_valid/in_stall   opcode, declared size, data byte, pin samples
//   out_     output     out_valid/out_stall DATA0, DCLK pulse, DCLK idle, nCONFIG, phase, last
//   cfg_     input      cfg_we              register index and write data
//
// An accepted item is held in the input register until the queue has room, then
// updates the sequencing state and drops one result record into a two-entry queue.
// A data byte taken in the loading phase with nSTATUS high leaves as eight beats,
// one per cycle while the output does not stall, LSB first; every other item
// leaves as one beat. The output serializer therefore sets the sustained rate.
// Reset is synchronous and active low; it releases nCONFIG and returns to idle.
// A stall on the output holds the current beat and, once the queue is full,
// backs up into the input stall.
module fpga_passive_serial_configurator
  import fpsc_pkg::*;
#(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_declared_size,
  input  logic [7:0]  in_data_byte,
  input  logic        in_nstatus_level,
  input  logic        in_cdone_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_data0_level,
  output logic        out_dclk_pulse,
  output logic        out_dclk_idle_high,
  output logic        out_nconfig_level,
  output logic [2:0]  out_phase,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Record handoff between the state update and the serializer.
  fpsc_rec_t rec;
  logic      rec_valid;
  logic      rec_ready;

  // The core owns the input register, the configuration registers and the
  // phase, tick, byte and pin-level state.
  fpsc_core #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_declared_size   (in_declared_size),
    .in_data_byte       (in_data_byte),
    .in_nstatus_level   (in_nstatus_level),
    .in_cdone_level     (in_cdone_level),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .rec_ready          (rec_ready),
    .rec_valid          (rec_valid),
    .rec                (rec)
  );

  // The serializer queues records so that a new item can be taken while a
  // byte is still being shifted out, and counts the eight bit beats.
  fpsc_ser u_ser (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_valid          (rec_valid),
    .rec                (rec),
    .rec_ready          (rec_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data0_level    (out_data0_level),
    .out_dclk_pulse     (out_dclk_pulse),
    .out_dclk_idle_high (out_dclk_idle_high),
    .out_nconfig_level  (out_nconfig_level),
    .out_phase          (out_phase),
    .out_last           (out_last)
  );

endmodule

@@ rtl/fpsc_checker.sv @@
// Port-level checks of the configurator and their binding to the top level.
`include "fpga_passive_serial_configurator_defines.svh"

module fpsc_checker
  import fpsc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_data0_level,
  input logic       out_dclk_pulse,
  input logic       out_dclk_idle_high,
  input logic       out_nconfig_level,
  input logic [2:0] out_phase,
  input logic       out_last
);

  `FPSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data0_level) && $stable(out_phase), "stalled output beat changed")

  // Clocked bits only come from a byte shifted in loading.
  `FPSC_ASSERT_NOW(a_pulse_phase, out_valid && out_dclk_pulse, out_phase == PH_LOAD || out_phase == PH_DONEWAIT, "DCLK pulse outside loading")

  `FPSC_ASSERT_NOW(a_done_levels, out_valid && out_dclk_idle_high, out_phase == PH_DONE && out_data0_level && !out_dclk_pulse, "done beat with wrong pin levels")

  // The eight bits of one byte are never split by another item.
  `FPSC_ASSERT_NEXT(a_byte_burst, out_valid && !out_stall && out_dclk_pulse && !out_last, out_valid && out_dclk_pulse, "byte burst interrupted")

  `FPSC_ASSERT_NOW(a_pulse_ncfg, out_valid && out_phase == PH_PULSE, !out_nconfig_level, "nCONFIG not low during the pulse")

endmodule

bind fpga_passive_serial_configurator fpsc_checker u_fpsc_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the passive serial FPGA configurator.
`timescale 1ns / 1ps

module tb;
  import fpsc_pkg::*;

  // The opcode value that the block has no use for.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int TICK_BITS = 16;
  // Cycles without any accepted beat on either channel before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Cycles allowed after the last result for anything unexpected to show up.
  localparam int TAIL_CYCLES = 40;

  // One host request as it is presented on the in_ channel.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] size;
    logic [7:0]  dbyte;
    logic        ns;
    logic        cd;
  } host_item_t;

  // The pin levels carried by one out_ beat, in port order.
  typedef struct packed {
    logic       d0;
    logic       pulse;
    logic       idle_high;
    logic       ncfg;
    logic [2:0] phase;
    logic       last;
  } pin_beat_t;

  // One full set of the four timing and size registers.
  typedef struct {
    logic [31:0] nbytes;
    logic [15:0] low_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] done_ticks;
  } setup_t;

  typedef enum logic {ROW_BEAT, ROW_SETUP} row_kind_t;

  typedef enum int {CALM, SEND_GAPS, RECV_STALLS, BOTH_IDLE} idle_mode_t;

  // A row of the directed table: either a request, with an optional fixed
  // expectation, or a register setup applied between requests.
  typedef struct {
    row_kind_t  kind;
    host_item_t item;
    logic       has_fixed;
    pin_beat_t  fixed;
    setup_t     setup;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [31:0] in_declared_size;
  logic [7:0]  in_data_byte;
  logic        in_nstatus_level;
  logic        in_cdone_level;
  logic        out_valid;
  logic        out_stall;
  logic        out_data0_level;
  logic        out_dclk_pulse;
  logic        out_dclk_idle_high;
  logic        out_nconfig_level;
  logic [2:0]  out_phase;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  fpga_passive_serial_configurator #(
    .TICK_COUNT_BITS(TICK_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_declared_size  (in_declared_size),
    .in_data_byte      (in_data_byte),
    .in_nstatus_level  (in_nstatus_level),
    .in_cdone_level    (in_cdone_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data0_level   (out_data0_level),
    .out_dclk_pulse    (out_dclk_pulse),
    .out_dclk_idle_high(out_dclk_idle_high),
    .out_nconfig_level (out_nconfig_level),
    .out_phase         (out_phase),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Shadow copy of the sequencer state and of the registers.
  logic [2:0]           m_phase;
  logic [TICK_BITS-1:0] m_ticks;
  logic [31:0]          m_sent;
  logic                 m_ncfg;
  logic                 m_d0;
  logic [31:0]          cfg_bytes;
  logic [15:0]          cfg_low;
  logic [15:0]          cfg_settle;
  logic [15:0]          cfg_done;

  // Beats still owed by the block, oldest first, and the beats of the
  // request that was just accepted.
  pin_beat_t pin_beats_due[$];
  pin_beat_t step_beats[$];

  int sender_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int quiet_cycles;

  dir_row_t dir_rows[$];

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Tick counter step: it saturates at all ones, and a saturated counter
  // counts as having reached any threshold.
  function automatic bit bump_ticks(logic [15:0] limit);
    if (m_ticks != '1) m_ticks = m_ticks + 1'b1;
    return (m_ticks >= limit) || (m_ticks == '1);
  endfunction

  // Pin levels as they stand once the current request has been applied.
  function automatic pin_beat_t pins(logic d0, logic pulse, logic last);
    pin_beat_t b;
    b.d0        = d0;
    b.pulse     = pulse;
    b.idle_high = (m_phase == PH_DONE);
    b.ncfg      = m_ncfg;
    b.phase     = m_phase;
    b.last      = last;
    return b;
  endfunction

  // Applies one request to the shadow sequencer and leaves the beats it
  // should produce in step_beats.
  function automatic void advance_sequencer(host_item_t it);
    bit shifted;
    shifted = 1'b0;
    step_beats.delete();
    case (it.op)
      OP_START: begin
        // A start is only taken when no sequence is running.
        if (m_phase == PH_IDLE || m_phase == PH_DONE || m_phase == PH_ERROR) begin
          m_d0    = 1'b0;
          m_sent  = '0;
          m_ticks = '0;
          if (it.size != cfg_bytes) begin
            m_ncfg  = 1'b1;
            m_phase = PH_ERROR;
          end else begin
            m_ncfg  = 1'b0;
            m_phase = PH_PULSE;
          end
        end
      end
      OP_TICK: begin
        case (m_phase)
          PH_PULSE: begin
            if (bump_ticks(cfg_low)) begin
              m_ncfg  = 1'b1;
              m_ticks = '0;
              m_phase = (cfg_settle == 0) ? PH_LOAD : PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (bump_ticks(cfg_settle)) begin
              m_ticks = '0;
              m_phase = PH_LOAD;
            end
          end
          PH_LOAD: begin
            if (!it.ns) m_phase = PH_ERROR;
          end
          PH_DONEWAIT: begin
            if (it.cd) begin
              m_d0    = 1'b1;
              m_phase = PH_DONE;
            end else if (bump_ticks(cfg_done)) begin
              m_phase = PH_ERROR;
            end
          end
          default: begin
          end
        endcase
      end
      OP_DATA: begin
        if (m_phase == PH_LOAD) begin
          if (!it.ns) begin
            m_phase = PH_ERROR;
          end else begin
            m_d0   = it.dbyte[7];
            m_sent = m_sent + 32'd1;
            if (m_sent == cfg_bytes) begin
              m_ticks = '0;
              m_phase = PH_DONEWAIT;
            end
            for (int i = 0; i < 8; i++) step_beats.push_back(pins(it.dbyte[i], 1'b1, i == 7));
            shifted = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!shifted) step_beats.push_back(pins(m_d0, 1'b0, 1'b1));
  endfunction

  function automatic dir_row_t beat_row(logic [1:0] op, logic [31:0] size, logic [7:0] dbyte,
                                        logic ns, logic cd);
    dir_row_t r;
    r.kind       = ROW_BEAT;
    r.item.op    = op;
    r.item.size  = size;
    r.item.dbyte = dbyte;
    r.item.ns    = ns;
    r.item.cd    = cd;
    r.has_fixed  = 1'b0;
    r.fixed      = '0;
    r.setup      = '{32'd0, 16'd0, 16'd0, 16'd0};
    return r;
  endfunction

  // A request whose single beat is written out by hand.
  function automatic dir_row_t fixed_row(logic [1:0] op, logic [31:0] size, logic [7:0] dbyte,
                                         logic [2:0] ph, logic ncfg, logic d0);
    dir_row_t r;
    r                 = beat_row(op, size, dbyte, 1'b1, 1'b0);
    r.has_fixed       = 1'b1;
    r.fixed.d0        = d0;
    r.fixed.pulse     = 1'b0;
    r.fixed.idle_high = (ph == PH_DONE);
    r.fixed.ncfg      = ncfg;
    r.fixed.phase     = ph;
    r.fixed.last      = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t setup_row(logic [31:0] nbytes, logic [15:0] low,
                                         logic [15:0] settle, logic [15:0] done_t);
    dir_row_t r;
    r       = beat_row(OP_SPARE, '0, '0, 1'b1, 1'b0);
    r.kind  = ROW_SETUP;
    r.setup = '{nbytes, low, settle, done_t};
    return r;
  endfunction

  function automatic void set_idle_mode(idle_mode_t mode);
    case (mode)
      CALM: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      SEND_GAPS: begin
        sender_idle_pct = 50;
        recv_stall_pct  = 0;
      end
      RECV_STALLS: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 50;
      end
      default: begin
        sender_idle_pct = 21;
        recv_stall_pct  = 21;
      end
    endcase
  endfunction

  // Picks the next request from the phase the sequencer is in, so that most
  // traffic walks a proper start, pulse, settle, load and done sequence with
  // random content. The rest is noise: spare opcodes, starts while busy and bytes
  // outside loading; noise does not count. Any request may carry a low nSTATUS sample.
  function automatic host_item_t next_item(output bit counts);
    host_item_t it;
    int roll;
    roll     = $urandom_range(99);
    it.op    = 2'($urandom_range(3));
    it.size  = $urandom();
    it.dbyte = 8'($urandom_range(255));
    it.ns    = ($urandom_range(9) != 0);
    it.cd    = 1'($urandom_range(1));
    counts   = 1'b0;
    case (m_phase)
      PH_PULSE, PH_STATUS: begin
        if (roll < 85) begin
          it.op  = OP_TICK;
          counts = 1'b1;
        end
      end
      PH_LOAD: begin
        if (roll < 70) begin
          it.op  = OP_DATA;
          counts = 1'b1;
        end else if (roll < 85) begin
          it.op  = OP_TICK;
          counts = 1'b1;
        end
      end
      PH_DONEWAIT: begin
        if (roll < 90) begin
          it.op  = OP_TICK;
          counts = 1'b1;
        end
      end
      default: begin
        if (roll < 90) begin
          it.op  = OP_START;
          counts = 1'b1;
          // Mostly a matching size; now and then a random one to hit the
          // size mismatch path.
          if ($urandom_range(4) != 0) it.size = cfg_bytes;
        end
      end
    endcase
    return it;
  endfunction

  // Presents one request, holds it through any stall, and books the beats
  // it must produce at the edge where it is taken.
  task automatic send_item(host_item_t it, logic has_fixed, pin_beat_t fixed);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= it.op;
    in_declared_size   <= it.size;
    in_data_byte       <= it.dbyte;
    in_nstatus_level   <= it.ns;
    in_cdone_level     <= it.cd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(it);
    if (has_fixed) begin
      pin_beats_due.push_back(fixed);
    end else begin
      foreach (step_beats[i]) pin_beats_due.push_back(step_beats[i]);
    end
  endtask

  // Stops sending and waits until every owed beat has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pin_beats_due.size() != 0) @(posedge clk);
  endtask

  // Registers are only touched once the block has gone quiet. Every request
  // yields at least one beat, so an empty queue means nothing is in flight.
  task automatic apply_setup(setup_t s);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BITSTREAM_BYTES;
    cfg_wdata <= s.nbytes;
    @(posedge clk);
    cfg_index <= REG_NCONFIG_LOW;
    cfg_wdata <= {16'd0, s.low_ticks};
    @(posedge clk);
    cfg_index <= REG_STATUS_WAIT;
    cfg_wdata <= {16'd0, s.settle_ticks};
    @(posedge clk);
    cfg_index <= REG_DONE_TIMEOUT;
    cfg_wdata <= {16'd0, s.done_ticks};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_bytes  = s.nbytes;
    cfg_low    = s.low_ticks;
    cfg_settle = s.settle_ticks;
    cfg_done   = s.done_ticks;
  endtask

  // The receiver stalls at random at the rate of the current idle mode.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every beat taken from the block is matched against the oldest one owed.
  always @(posedge clk) begin
    pin_beat_t got;
    pin_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_data0_level, out_dclk_pulse, out_dclk_idle_high, out_nconfig_level,
             out_phase, out_last};
      if (pin_beats_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: beat with nothing owed: d0=%b dclk=%b idle=%b ncfg=%b phase=%0d last=%b",
                   $realtime, got.d0, got.pulse, got.idle_high, got.ncfg, got.phase, got.last);
        mismatches++;
      end else begin
        want = pin_beats_due.pop_front();
        if (got != want) begin
          if (mismatches < 10)
            $display({"%0t: beat mismatch (expected/actual): d0 %b/%b dclk %b/%b idle %b/%b ",
                      "ncfg %b/%b phase %0d/%0d last %b/%b"}, $realtime,
                     want.d0, got.d0, want.pulse, got.pulse, want.idle_high, got.idle_high,
                     want.ncfg, got.ncfg, want.phase, got.phase, want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a run where no beat moves on either side for too long is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    setup_t     plan [6];
    int         quota [6];
    idle_mode_t modes [6];
    host_item_t it;
    bit         counts;
    int         taken;

    // Every input is known from the first instant, reset included.
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_opcode          <= OP_TICK;
    in_declared_size   <= '0;
    in_data_byte       <= '0;
    in_nstatus_level   <= 1'b1;
    in_cdone_level     <= 1'b0;
    out_stall          <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_BITSTREAM_BYTES;
    cfg_wdata          <= '0;
    mismatches   = 0;
    quiet_cycles = 0;
    set_idle_mode(CALM);

    // Shadow state as it stands out of reset.
    m_phase    = PH_IDLE;
    m_ticks    = '0;
    m_sent     = '0;
    m_ncfg     = 1'b1;
    m_d0       = 1'b0;
    cfg_bytes  = RST_BITSTREAM_BYTES;
    cfg_low    = RST_NCONFIG_LOW;
    cfg_settle = RST_STATUS_WAIT;
    cfg_done   = RST_DONE_TIMEOUT;

    // Directed part. With the reset registers (one byte, long pulse and
    // settle times) only the idle, error and pulse behavior is reachable,
    // so those rows carry their beats written out by hand.
    dir_rows.push_back(fixed_row(OP_TICK, 32'd0, 8'h00, PH_IDLE, 1'b1, 1'b0));
    dir_rows.push_back(fixed_row(OP_DATA, 32'd0, 8'hFF, PH_IDLE, 1'b1, 1'b0));
    dir_rows.push_back(fixed_row(OP_SPARE, 32'hFFFF_FFFF, 8'hFF, PH_IDLE, 1'b1, 1'b0));
    // A wrong size goes straight to error and leaves nCONFIG released.
    dir_rows.push_back(fixed_row(OP_START, 32'hFFFF_FFFF, 8'h00, PH_ERROR, 1'b1, 1'b0));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd0, 8'h00, PH_ERROR, 1'b1, 1'b0));
    // Restart out of error with the right size, then a start while busy.
    dir_rows.push_back(fixed_row(OP_START, 32'd1, 8'h00, PH_PULSE, 1'b0, 1'b0));
    dir_rows.push_back(fixed_row(OP_START, 32'd1, 8'h00, PH_PULSE, 1'b0, 1'b0));
    dir_rows.push_back(fixed_row(OP_TICK, 32'd0, 8'h00, PH_PULSE, 1'b0, 1'b0));
    // Zero pulse, settle and timeout lengths: the next tick releases nCONFIG
    // and goes straight to loading, and the first tick without the done pin
    // high times out.
    dir_rows.push_back(setup_row(32'd2, 16'd0, 16'd0, 16'd0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(beat_row(OP_START, 32'd2, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_DATA, 32'd0, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b1));
    dir_rows.push_back(beat_row(OP_DATA, 32'd0, 8'hFF, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b0));
    // nSTATUS low on a data byte aborts without shifting any bits.
    dir_rows.push_back(beat_row(OP_START, 32'd2, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_DATA, 32'd0, 8'hA5, 1'b0, 1'b0));
    // A clean run that ends in done, then a restart out of done.
    dir_rows.push_back(beat_row(OP_START, 32'd2, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_DATA, 32'd0, 8'h5A, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_DATA, 32'd0, 8'h81, 1'b1, 1'b0));
    dir_rows.push_back(beat_row(OP_TICK, 32'd0, 8'h00, 1'b1, 1'b1));
    dir_rows.push_back(beat_row(OP_START, 32'd2, 8'h00, 1'b1, 1'b0));

    // Settings for the random part, each with its own idle pattern. The
    // all-ones byte count keeps the block loading for good, and the zero
    // count with the longest pulse parks it in the pulse phase.
    plan[0]  = '{32'd1, 16'd1, 16'd1, 16'd2};
    plan[1]  = '{32'd3, 16'd2, 16'd0, 16'd3};
    plan[2]  = '{32'hFFFF_FFFF, 16'd1, 16'd2, 16'hFFFF};
    plan[3]  = '{32'd2, 16'd0, 16'd1, 16'd1};
    plan[4]  = '{32'd0, 16'hFFFF, 16'hFFFF, 16'd0};
    plan[5]  = '{32'($urandom_range(4, 1)), 16'($urandom_range(3)), 16'($urandom_range(3)),
                 16'($urandom_range(3))};
    quota    = '{12, 12, 12, 12, 6, 10};
    modes    = '{CALM, SEND_GAPS, RECV_STALLS, BOTH_IDLE, CALM, SEND_GAPS};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_SETUP) begin
        apply_setup(dir_rows[r].setup);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].has_fixed, dir_rows[r].fixed);
      end
    end

    // Random part. Each setting starts from a quiet block, which also gives
    // the pause where the sender waits for every owed beat to come back.
    for (int p = 0; p < 6; p++) begin
      apply_setup(plan[p]);
      set_idle_mode(modes[p]);
      taken = 0;
      while (taken < quota[p]) begin
        it = next_item(counts);
        send_item(it, 1'b0, '0);
        taken += counts;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fpsc_pkg.sv
rtl/fpsc_core.sv
rtl/fpsc_ser.sv
rtl/fpga_passive_serial_configurator.sv
rtl/fpsc_checker.sv
verif/tb.sv
